FILE: src/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int KEY_MAX_BYTES = 256;
  localparam int KEY_AW        = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam int KEY_LEN_W     = 9;
  localparam int SBOX_DEPTH    = 256;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(1);
  localparam logic [KEY_LEN_W-1:0] KEY_MAX_LEN   = KEY_LEN_W'(KEY_MAX_BYTES);

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    OP_LOAD_KEY  = 2'd0,
    OP_SCHEDULE  = 2'd1,
    OP_DECIPHER  = 2'd2
  } opcode_t;

  // datapath commands, one step of the sequencer each
  typedef struct packed {
    logic key_wr;
    logic capture;
    logic sb_clear;
    logic ks_rd;
    logic ks_jrd;
    logic ks_w1;
    logic ks_w2;
    logic dc_rd;
    logic dc_jrd;
    logic dc_w1;
    logic dc_w2;
  } cmd_t;

  typedef struct packed {
    logic ks_last;
    logic out_free;
  } status_t;

  // ascii hex character to nibble, modulo 256
  function automatic byte_t hex_nibble(input byte_t ch);
    byte_t res;
    if (ch >= 8'd48 && ch <= 8'd57) begin
      res = ch - 8'd48;
    end else begin
      res = ch - 8'd87;
    end
    return res;
  endfunction

endpackage

FILE: src/rc4_in_if.sv
`timescale 1ns / 1ps

interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] key_index;
  logic [7:0] key_byte;
  logic [7:0] hex_high_char;
  logic [7:0] hex_low_char;

  modport source (
    output valid, opcode, key_index, key_byte, hex_high_char, hex_low_char,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_index, key_byte, hex_high_char, hex_low_char,
    output ready
  );
endinterface

FILE: src/rc4_out_if.sv
`timescale 1ns / 1ps

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;

  modport source (
    output valid, plain_byte,
    input  ready
  );
  modport sink (
    input  valid, plain_byte,
    output ready
  );
endinterface

FILE: src/rc4_datapath.sv
`timescale 1ns / 1ps

module rc4_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rc4_pkg::cmd_t                 cmd,
  input  logic [7:0]                    key_index,
  input  logic [7:0]                    key_byte,
  input  logic [7:0]                    hex_high_char,
  input  logic [7:0]                    hex_low_char,
  input  logic                          cfg_we,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [7:0]                    plain_byte,
  output rc4_pkg::status_t              status
);
  import rc4_pkg::*;

  logic [KEY_LEN_W-1:0] key_len_r;
  logic [KEY_LEN_W-1:0] len_eff;
  logic [KEY_LEN_W-1:0] k_plus;
  logic [KEY_AW-1:0]    k_r;
  byte_t                i_r, j_r, n_r, jj_r;
  byte_t                si_r, sj_r, t_r, cbyte_r, plain_r;
  logic                 out_valid_r;

  // sbox store with per-entry valid bits, invalid entries read as identity
  byte_t                sb_mem [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] sb_vld_r;
  byte_t                sb_q, sb_raddr_q;
  logic                 sb_vld_q;
  byte_t                sb_rdata;
  logic                 sb_re, sb_we;
  byte_t                sb_raddr, sb_waddr, sb_wdata;

  byte_t                key_mem [KEY_MAX_BYTES];
  byte_t                key_q;
  logic                 key_in_range;

  byte_t                jj_sum, j_sum, ks;
  byte_t                hi_nib, lo_nib;

  assign sb_rdata = sb_vld_q ? sb_q : sb_raddr_q;
  assign jj_sum   = jj_r + sb_rdata + key_q;
  assign j_sum    = j_r + sb_rdata;
  assign ks       = (t_r == j_r) ? si_r : ((t_r == i_r) ? sj_r : sb_rdata);

  assign hi_nib   = hex_nibble(hex_high_char);
  assign lo_nib   = hex_nibble(hex_low_char);

  assign len_eff = (key_len_r == '0) ? KEY_LEN_W'(1) :
                   ((key_len_r > KEY_MAX_LEN) ? KEY_MAX_LEN : key_len_r);
  assign k_plus  = KEY_LEN_W'(k_r) + KEY_LEN_W'(1);

  assign key_in_range = KEY_LEN_W'(key_index) < KEY_MAX_LEN;

  always_comb begin
    sb_re    = 1'b0;
    sb_raddr = n_r;
    sb_we    = 1'b0;
    sb_waddr = n_r;
    sb_wdata = sb_rdata;
    priority if (cmd.ks_rd) begin
      sb_re    = 1'b1;
      sb_raddr = n_r;
    end else if (cmd.ks_jrd) begin
      sb_re    = 1'b1;
      sb_raddr = jj_sum;
    end else if (cmd.ks_w1) begin
      sb_we    = 1'b1;
      sb_waddr = n_r;
      sb_wdata = sb_rdata;
    end else if (cmd.ks_w2) begin
      sb_we    = 1'b1;
      sb_waddr = jj_r;
      sb_wdata = si_r;
    end else if (cmd.dc_rd) begin
      sb_re    = 1'b1;
      sb_raddr = i_r + 8'd1;
    end else if (cmd.dc_jrd) begin
      sb_re    = 1'b1;
      sb_raddr = j_sum;
    end else if (cmd.dc_w1) begin
      sb_we    = 1'b1;
      sb_waddr = i_r;
      sb_wdata = sb_rdata;
      sb_re    = 1'b1;
      sb_raddr = si_r + sb_rdata;
    end else if (cmd.dc_w2) begin
      sb_we    = 1'b1;
      sb_waddr = j_r;
      sb_wdata = si_r;
    end else begin
      sb_re    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sb_we) begin
      sb_mem[sb_waddr] <= sb_wdata;
    end
    if (sb_re) begin
      sb_q       <= sb_mem[sb_raddr];
      sb_raddr_q <= sb_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= '0;
      sb_vld_q <= 1'b0;
    end else begin
      if (sb_re) begin
        sb_vld_q <= sb_vld_r[sb_raddr];
      end
      if (cmd.sb_clear) begin
        sb_vld_r <= '0;
      end else if (sb_we) begin
        sb_vld_r[sb_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_wr && key_in_range) begin
      key_mem[key_index[KEY_AW-1:0]] <= key_byte;
    end
    if (cmd.ks_rd) begin
      key_q <= key_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r   <= KEY_LEN_RESET;
      i_r         <= '0;
      j_r         <= '0;
      n_r         <= '0;
      jj_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_len_r <= cfg_wdata;
      end
      if (cmd.sb_clear) begin
        i_r  <= '0;
        j_r  <= '0;
        n_r  <= '0;
        jj_r <= '0;
        k_r  <= '0;
      end
      if (cmd.ks_jrd) begin
        jj_r <= jj_sum;
      end
      if (cmd.ks_w2) begin
        n_r <= n_r + 8'd1;
        k_r <= (k_plus >= len_eff) ? '0 : k_plus[KEY_AW-1:0];
      end
      if (cmd.dc_rd) begin
        i_r <= i_r + 8'd1;
      end
      if (cmd.dc_jrd) begin
        j_r <= j_sum;
      end
      if (cmd.dc_w2) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cbyte_r <= {hi_nib[3:0], 4'h0} + lo_nib;
    end
    if (cmd.ks_jrd || cmd.dc_jrd) begin
      si_r <= sb_rdata;
    end
    if (cmd.dc_w1) begin
      sj_r <= sb_rdata;
      t_r  <= si_r + sb_rdata;
    end
    if (cmd.dc_w2) begin
      plain_r <= cbyte_r ^ ks;
    end
  end

  assign status     = '{ks_last: (n_r == 8'hFF), out_free: (!out_valid_r || out_ready)};
  assign out_valid  = out_valid_r;
  assign plain_byte = plain_r;

endmodule

FILE: src/rc4_ctrl.sv
`timescale 1ns / 1ps

module rc4_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_opcode,
  input  rc4_pkg::status_t status,
  output logic             in_ready,
  output rc4_pkg::cmd_t    cmd
);
  import rc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_CLR,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_W1,
    ST_KS_W2,
    ST_DC_RD,
    ST_DC_J,
    ST_DC_W1,
    ST_DC_W2
  } state_t;

  state_t state_r;
  logic   fire;

  assign in_ready = (state_r == ST_IDLE);
  assign fire     = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          cmd.key_wr  = (in_opcode == OP_LOAD_KEY);
          cmd.capture = (in_opcode == OP_DECIPHER);
        end
      end
      ST_KS_CLR: cmd.sb_clear = 1'b1;
      ST_KS_RD:  cmd.ks_rd    = 1'b1;
      ST_KS_J:   cmd.ks_jrd   = 1'b1;
      ST_KS_W1:  cmd.ks_w1    = 1'b1;
      ST_KS_W2:  cmd.ks_w2    = 1'b1;
      ST_DC_RD:  cmd.dc_rd    = 1'b1;
      ST_DC_J:   cmd.dc_jrd   = 1'b1;
      ST_DC_W1:  cmd.dc_w1    = 1'b1;
      ST_DC_W2:  cmd.dc_w2    = status.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (fire) begin
            case (in_opcode)
              OP_SCHEDULE: state_r <= ST_KS_CLR;
              OP_DECIPHER: state_r <= ST_DC_RD;
              default:     state_r <= ST_IDLE;
            endcase
          end
        end
        ST_KS_CLR: state_r <= ST_KS_RD;
        ST_KS_RD:  state_r <= ST_KS_J;
        ST_KS_J:   state_r <= ST_KS_W1;
        ST_KS_W1:  state_r <= ST_KS_W2;
        ST_KS_W2:  state_r <= status.ks_last ? ST_IDLE : ST_KS_RD;
        ST_DC_RD:  state_r <= ST_DC_J;
        ST_DC_J:   state_r <= ST_DC_W1;
        ST_DC_W1:  state_r <= ST_DC_W2;
        ST_DC_W2: begin
          if (status.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/rc4_stream_decipher.sv
`timescale 1ns / 1ps
// rc4 decipher engine: key store, key schedule sequencer, keystream datapath
// key load: byte written on acceptance, intake stays open; schedule, after acceptance:
//   one clear step, then 256 steps of sbox read, j read and two swap writes
// decipher: steps set by the single sbox port (two dependent reads, swap writes,
//   output read); intake stays closed until the result is written
// reset: synchronous active low; sbox reads as identity, i = j = 0, key_length 1

module rc4_stream_decipher (
  input  logic                          clk,
  input  logic                          rst_n,
  rc4_in_if.sink                        in_ch,
  rc4_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] cfg_wdata
);
  import rc4_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // sequencer: accepts a transaction only while idle, then walks the steps
  rc4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // sbox, key store, indices and the output register
  rc4_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .key_index     (in_ch.key_index),
    .key_byte      (in_ch.key_byte),
    .hex_high_char (in_ch.hex_high_char),
    .hex_low_char  (in_ch.hex_low_char),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .plain_byte    (out_ch.plain_byte),
    .status        (status)
  );

  assign in_ch.ready = in_ready;

  // a schedule transaction blocks intake on the next cycle
  a_sched_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.opcode == OP_SCHEDULE) |=> !in_ch.ready)
    else $error("intake open right after schedule transaction");

  // a new result is only written when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dc_w2 |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // results only come out of the final decipher step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.dc_w2))
    else $error("result valid without decipher step");

  // the sbox clear only happens with the sequencer busy
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sb_clear |-> !in_ch.ready)
    else $error("sbox clear while idle");

endmodule
